>>> src/assert_macros.svh
// Assertion macros for the port-level checker of the trajectory generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks cons in the same cycle as ante, clocked by clk and held off by reset.
`define CSG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks cons in the cycle after ante.
`define CSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/csg_pkg.sv
// Shared widths, register indexes and controller/datapath signal groups.
package csg_pkg;

  localparam int POS_W      = 48;
  localparam int PER_W      = 16;
  localparam int TICK_W     = 32;
  localparam int REM_W      = 33;
  localparam int W_W        = 32;
  localparam int ROM_W      = 31;
  localparam int MAG_SPLIT  = 24;
  localparam int SHIFT_FULL = 30;
  localparam int SHIFT_HALF = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_TDATA_W = 88;

  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_COUNT = 2'd2;

  localparam logic [PER_W-1:0] PERIOD_TICKS_RST = 16'd1000;
  localparam logic [PER_W-1:0] PERIOD_COUNT_RST = 16'd2;

  localparam logic [63:0]    PI_Q30  = 64'd3373259426;
  localparam logic [W_W-1:0] ONE_Q30 = 32'h4000_0000;

  // Commands from the controller to the datapath, one cycle each.
  typedef struct packed {
    logic accept;
    logic prep;
    logic classify;
    logic div_start;
    logic k_set;
    logic fold;
    logic wcalc;
    logic mul_lo;
    logic mul_hi;
    logic load_out;
  } csg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_seg;
    logic div_done;
    logic out_free;
  } csg_sts_t;

endpackage

>>> src/csg_div.sv
// Restoring divider, one quotient bit per cycle.
module csg_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Bring down the next dividend bit and try the subtraction.
  always_comb begin
    shifted = {rem_r, num_r[NUM_W-1]};
    fits    = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The quotient bits shift in behind the dividend bits.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], fits};
      rem_r <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = num_r;
  assign rem  = rem_r;

endmodule

>>> src/csg_cos_rom.sv
// Quarter-wave cosine table in Q30 with a registered read port.
module csg_cos_rom #(
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic [$clog2(DEPTH + 1)-1:0]     addr,
  output logic [csg_pkg::ROM_W-1:0]        data
);

  logic [csg_pkg::ROM_W-1:0] cos_tbl [DEPTH + 1];
  logic [csg_pkg::ROM_W-1:0] data_r;

  // Eight Taylor terms in integer arithmetic, clamped to [0, 1.0].
  function automatic logic [csg_pkg::ROM_W-1:0] cos_taylor(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    x2  = (x * x) >> 30;
    t   = 64'(csg_pkg::ONE_Q30);
    sum = signed'(64'(csg_pkg::ONE_Q30));
    t   = ((t * x2) >> 30) / 64'd2;
    sum = sum - signed'(t);
    t   = ((t * x2) >> 30) / 64'd12;
    sum = sum + signed'(t);
    t   = ((t * x2) >> 30) / 64'd30;
    sum = sum - signed'(t);
    t   = ((t * x2) >> 30) / 64'd56;
    sum = sum + signed'(t);
    t   = ((t * x2) >> 30) / 64'd90;
    sum = sum - signed'(t);
    t   = ((t * x2) >> 30) / 64'd132;
    sum = sum + signed'(t);
    t   = ((t * x2) >> 30) / 64'd182;
    sum = sum - signed'(t);
    if (sum < 0) begin
      sum = '0;
    end else if (sum > signed'(64'(csg_pkg::ONE_Q30))) begin
      sum = signed'(64'(csg_pkg::ONE_Q30));
    end
    return csg_pkg::ROM_W'(sum);
  endfunction

  for (genvar gi = 0; gi <= DEPTH; gi++) begin : g_entry
    localparam logic [63:0] X =
      (64'(gi) * csg_pkg::PI_Q30 + 64'(DEPTH)) / (64'd2 * 64'(DEPTH));
    localparam logic [csg_pkg::ROM_W-1:0] VAL = cos_taylor(X);
    assign cos_tbl[gi] = VAL;
  end

  always_ff @(posedge clk) begin
    data_r <= cos_tbl[addr];
  end

  assign data = data_r;

endmodule

>>> src/csg_datapath.sv
// Datapath: registers, segment selection, phase division, cosine and scaling.
module csg_datapath #(
  parameter int COS_TABLE_DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [csg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [csg_pkg::POS_W-1:0]             cfg_wdata,
  input  logic [csg_pkg::POS_W-1:0]             present_target,
  input  csg_pkg::csg_cmd_t                     cmd,
  output csg_pkg::csg_sts_t                     sts,
  input  logic                                  out_tready,
  output logic                                  out_tvalid,
  output logic [csg_pkg::POS_W-1:0]             out_new_target,
  output logic                                  out_target_written,
  output logic [csg_pkg::REM_W-1:0]             out_ticks_remaining,
  output logic                                  out_move_done
);

  localparam int POS_W  = csg_pkg::POS_W;
  localparam int PER_W  = csg_pkg::PER_W;
  localparam int TICK_W = csg_pkg::TICK_W;
  localparam int REM_W  = csg_pkg::REM_W;
  localparam int W_W    = csg_pkg::W_W;
  localparam int SPLIT  = csg_pkg::MAG_SPLIT;
  localparam int CMP_W  = TICK_W + 2;
  localparam int KNUM_W = PER_W + $clog2(8 * COS_TABLE_DEPTH) + 1;
  localparam int DIV_W  = (KNUM_W > TICK_W) ? KNUM_W : TICK_W;
  localparam int DEN_W  = PER_W + 1;
  localparam int K_W    = $clog2(4 * COS_TABLE_DEPTH + 1);
  localparam int A_W    = $clog2(COS_TABLE_DEPTH + 1);
  localparam int ACC_W  = POS_W + W_W - 1;
  localparam int PROD_W = SPLIT + W_W;

  localparam logic [DIV_W-1:0] EightD = DIV_W'(8 * COS_TABLE_DEPTH);
  localparam logic [K_W-1:0]   KD     = K_W'(COS_TABLE_DEPTH);
  localparam logic [K_W-1:0]   K2D    = K_W'(2 * COS_TABLE_DEPTH);
  localparam logic [K_W-1:0]   K3D    = K_W'(3 * COS_TABLE_DEPTH);
  localparam logic [K_W-1:0]   K4D    = K_W'(4 * COS_TABLE_DEPTH);
  localparam logic [ACC_W-1:0] RndFull = ACC_W'(1) << (csg_pkg::SHIFT_FULL - 1);
  localparam logic [ACC_W-1:0] RndHalf = ACC_W'(1) << (csg_pkg::SHIFT_HALF - 1);

  typedef enum logic [1:0] {SEG_NONE, SEG_OUT, SEG_SWING, SEG_BACK} seg_t;

  // Configuration and move state.
  logic [POS_W-1:0]  amplitude_r;
  logic [PER_W-1:0]  period_ticks_r;
  logic [PER_W-1:0]  period_count_r;
  logic [TICK_W-1:0] tick_index_r;
  logic [POS_W-1:0]  segment_base_r;

  // Per-transaction working registers.
  logic [POS_W-1:0]        sample_r;
  logic [TICK_W-1:0]       c_r;
  logic [TICK_W-1:0]       total_r;
  logic signed [REM_W-1:0] rem_r;
  logic                    done_r;
  logic signed [CMP_W-1:0] tmh_r;
  logic [POS_W-1:0]        mag_r;
  logic                    a_neg_r;
  seg_t                    seg_r;
  logic [DIV_W-1:0]        div_num_r;
  logic [DEN_W-1:0]        div_den_r;
  logic [A_W-1:0]          rom_addr_r;
  logic                    cos_neg_r;
  logic [W_W-1:0]          w_r;
  logic [ACC_W-1:0]        acc_r;

  // Result register.
  logic              out_valid_r;
  logic [POS_W-1:0]  out_target_r;
  logic              out_wr_r;
  logic [REM_W-1:0]  out_rem_r;
  logic              out_done_r;

  logic [PER_W-2:0]         half;
  logic signed [CMP_W-1:0]  c_s;
  logic signed [CMP_W-1:0]  half_s;
  logic signed [CMP_W-1:0]  total_s;
  logic signed [REM_W-1:0]  rem_nxt;
  logic [POS_W-1:0]         mag_nxt;
  seg_t                     seg_cur;
  logic [TICK_W-1:0]        phase;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quot;
  logic [DEN_W-1:0]         div_rem;
  logic [DIV_W-1:0]         k_num;
  logic [K_W-1:0]           k;
  logic [A_W-1:0]           addr_nxt;
  logic                     cos_neg_nxt;
  logic [csg_pkg::ROM_W-1:0] rom_data;
  logic [SPLIT-1:0]         mul_a;
  logic [PROD_W-1:0]        mul_p;
  logic [POS_W-1:0]         m;
  logic                     neg;
  logic [POS_W-1:0]         tgt_nxt;

  assign half    = period_ticks_r[PER_W-1:1];
  assign c_s     = signed'({2'b00, c_r});
  assign half_s  = signed'(CMP_W'(half));
  assign total_s = signed'({2'b00, total_r});
  assign rem_nxt = signed'({1'b0, total_r}) - signed'({1'b0, c_r});
  assign mag_nxt = amplitude_r[POS_W-1] ? (~amplitude_r + 1'b1) : amplitude_r;

  // Segment of this tick; the tests run in priority order.
  always_comb begin
    if (c_s <= half_s) begin
      seg_cur = SEG_OUT;
    end else if (c_s <= tmh_r) begin
      seg_cur = SEG_SWING;
    end else if (c_s <= total_s) begin
      seg_cur = SEG_BACK;
    end else begin
      seg_cur = SEG_NONE;
    end
    case (seg_cur)
      SEG_OUT:   phase = c_r;
      SEG_SWING: phase = c_r - TICK_W'(half);
      SEG_BACK:  phase = TICK_W'(c_s - tmh_r);
      default:   phase = c_r;
    endcase
  end

  csg_div #(
    .NUM_W (DIV_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // Table index from the reduced phase: round(8D * ph / (2P)).
  assign k_num = DIV_W'(div_rem[PER_W-1:0]) * EightD + DIV_W'(period_ticks_r);
  assign k     = div_quot[K_W-1:0];

  // Quarter-wave folding; an index of a whole turn lands on entry zero.
  always_comb begin
    if (k < KD) begin
      addr_nxt    = A_W'(k);
      cos_neg_nxt = 1'b0;
    end else if (k < K2D) begin
      addr_nxt    = A_W'(K2D - k);
      cos_neg_nxt = 1'b1;
    end else if (k < K3D) begin
      addr_nxt    = A_W'(k - K2D);
      cos_neg_nxt = 1'b1;
    end else begin
      addr_nxt    = A_W'(K4D - k);
      cos_neg_nxt = 1'b0;
    end
  end

  csg_cos_rom #(
    .DEPTH (COS_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr_r),
    .data (rom_data)
  );

  // One 24 x 32 multiplier takes the low and then the high half of |A|.
  assign mul_a = cmd.mul_hi ? mag_r[POS_W-1:SPLIT] : mag_r[SPLIT-1:0];
  assign mul_p = PROD_W'(mul_a) * PROD_W'(w_r);

  always_comb begin
    if (seg_r == SEG_SWING) begin
      m = acc_r[POS_W+csg_pkg::SHIFT_FULL-1:csg_pkg::SHIFT_FULL];
    end else begin
      m = acc_r[POS_W+csg_pkg::SHIFT_HALF-1:csg_pkg::SHIFT_HALF];
    end
    neg     = a_neg_r ^ (seg_r != SEG_OUT);
    tgt_nxt = neg ? (segment_base_r - m) : (segment_base_r + m);
  end

  // Configuration, move state and result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r    <= '0;
      period_ticks_r <= csg_pkg::PERIOD_TICKS_RST;
      period_count_r <= csg_pkg::PERIOD_COUNT_RST;
      tick_index_r   <= '0;
      segment_base_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          csg_pkg::CFG_AMPLITUDE:    amplitude_r    <= cfg_wdata;
          csg_pkg::CFG_PERIOD_TICKS: period_ticks_r <= cfg_wdata[PER_W-1:0];
          csg_pkg::CFG_PERIOD_COUNT: period_count_r <= cfg_wdata[PER_W-1:0];
          default: ;
        endcase
      end
      if (cmd.prep) begin
        tick_index_r <= (rem_nxt <= 0) ? '0 : c_r;
      end
      if (cmd.classify && seg_cur != SEG_NONE && phase == TICK_W'(1)) begin
        segment_base_r <= sample_r;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= present_target;
      c_r      <= tick_index_r + 1'b1;
      total_r  <= TICK_W'(period_count_r) * TICK_W'(period_ticks_r);
    end
    if (cmd.prep) begin
      rem_r   <= rem_nxt;
      done_r  <= rem_nxt <= 0;
      tmh_r   <= total_s - half_s;
      mag_r   <= mag_nxt;
      a_neg_r <= amplitude_r[POS_W-1];
    end
    if (cmd.classify) begin
      seg_r     <= seg_cur;
      div_num_r <= DIV_W'(phase);
      div_den_r <= {1'b0, period_ticks_r};
    end
    if (cmd.k_set) begin
      div_num_r <= k_num;
      div_den_r <= {period_ticks_r, 1'b0};
    end
    if (cmd.fold) begin
      rom_addr_r <= addr_nxt;
      cos_neg_r  <= cos_neg_nxt;
    end
    if (cmd.wcalc) begin
      w_r <= cos_neg_r ? (csg_pkg::ONE_Q30 + W_W'(rom_data))
                       : (csg_pkg::ONE_Q30 - W_W'(rom_data));
    end
    if (cmd.mul_lo) begin
      acc_r <= ACC_W'(mul_p) + ((seg_r == SEG_SWING) ? RndFull : RndHalf);
    end
    if (cmd.mul_hi) begin
      acc_r <= acc_r + (ACC_W'(mul_p) << SPLIT);
    end
    if (cmd.load_out) begin
      out_target_r <= (seg_r == SEG_NONE) ? '0 : tgt_nxt;
      out_wr_r     <= seg_r != SEG_NONE;
      out_rem_r    <= rem_r;
      out_done_r   <= done_r;
    end
  end

  assign sts.in_seg   = seg_cur != SEG_NONE;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid          = out_valid_r;
  assign out_new_target      = out_target_r;
  assign out_target_written  = out_wr_r;
  assign out_ticks_remaining = out_rem_r;
  assign out_move_done       = out_done_r;

endmodule

>>> src/csg_ctrl.sv
// Controller: steps a tick through setup, two divisions, lookup and scaling, or past them when it is in no segment.
module csg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output csg_pkg::csg_cmd_t cmd,
  input  csg_pkg::csg_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CLASS,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_K_SET,
    ST_K_GO,
    ST_K_WAIT,
    ST_FOLD,
    ST_ROM,
    ST_WCALC,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_tready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_CLASS;
      end
      ST_CLASS: begin
        cmd.classify = 1'b1;
        state_nxt    = sts.in_seg ? ST_MOD_GO : ST_FINISH;
      end
      ST_MOD_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_K_SET;
        end
      end
      ST_K_SET: begin
        cmd.k_set = 1'b1;
        state_nxt = ST_K_GO;
      end
      ST_K_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_K_WAIT;
      end
      ST_K_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = ST_ROM;
      end
      ST_ROM: begin
        state_nxt = ST_WCALC;
      end
      ST_WCALC: begin
        cmd.wcalc = 1'b1;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= state_nxt == ST_IDLE;
    end
  end

  assign in_tready = in_tready_r;

endmodule

>>> src/cosine_swing_trajectory_gen.sv
// Top level of the cosine swing trajectory generator for one joint.
//
//   channel  | direction | contents
//   ---------+-----------+-----------------------------------------------------
//   in_      | slave     | one tick: present target position
//   out_     | master    | one result per tick: new target, flags, ticks left
//   cfg_     | write     | amplitude, period in ticks, number of periods
//
// A tick inside a segment runs two divisions on the shared serial divider, one
// bit per cycle; the divider is 32 bits wide at the default table depth. A tick
// outside every segment skips the divisions, the lookup and the scaling.
// Reset (rst_n low at a clock edge) clears the tick counter, the segment base
// and the registers to their defaults and holds the input not ready; the cosine
// table is constant and needs no fill. A stalled result holds in the output
// register while the next tick is already taken and worked on; only the final
// load waits for it.
module cosine_swing_trajectory_gen #(
  parameter int COS_TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input transactions.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [csg_pkg::POS_W-1:0]         in_tdata,   // [47:0] present_target
  // Result transactions.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [csg_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [47:0] new_target,
                                                        // [80:48] ticks_remaining,
                                                        // [87:81] zero
  output logic                              out_tuser,  // [0] target_written
  output logic                              out_tlast,  // move_done
  // Register writes.
  input  logic                              cfg_we,
  input  logic [csg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csg_pkg::POS_W-1:0]         cfg_wdata
);

  localparam int PAD_W = csg_pkg::OUT_TDATA_W - csg_pkg::REM_W - csg_pkg::POS_W;

  csg_pkg::csg_cmd_t cmd;
  csg_pkg::csg_sts_t sts;

  logic [csg_pkg::POS_W-1:0] new_target;
  logic [csg_pkg::REM_W-1:0] ticks_remaining;

  // The controller sequences each accepted transaction; it sees the datapath
  // only through the command and status groups.
  csg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the registers, the move state, the divider, the
  // cosine table, the multiplier and the result register.
  csg_datapath #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .present_target      (in_tdata),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_tready          (out_tready),
    .out_tvalid          (out_tvalid),
    .out_new_target      (new_target),
    .out_target_written  (out_tuser),
    .out_ticks_remaining (ticks_remaining),
    .out_move_done       (out_tlast)
  );

  // The result is packed with the target in the low bits.
  assign out_tdata = {{PAD_W{1'b0}}, ticks_remaining, new_target};

endmodule

>>> src/csg_checker.sv
// Port-level checks of the trajectory generator, bound to its top level.
`include "assert_macros.svh"

module csg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [csg_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);

  // A stalled result must not change.
  `CSG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "result changed while stalled")

  // The done flag matches a remaining tick count of zero or less.
  `CSG_ASSERT_NOW(a_done_flag, out_tvalid, out_tlast == (out_tdata[80] || (out_tdata[80:48] == 33'd0)), "done flag disagrees with ticks remaining")

  // A tick outside every segment reports a zero target.
  `CSG_ASSERT_NOW(a_idle_target, out_tvalid && !out_tuser, out_tdata[47:0] == 48'd0, "unwritten target is not zero")

  // One transaction is worked on at a time.
  `CSG_ASSERT_NEXT(a_one_tick, in_tvalid && in_tready, !in_tready, "ready stayed high after an accepted transaction")

endmodule

bind cosine_swing_trajectory_gen csg_checker u_checker (.*);

>>> dv/cosine_swing_trajectory_gen_checker.sv
// Checker for the cosine swing trajectory generator: predicts each tick and compares results.
module cosine_swing_trajectory_gen_checker #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [csg_pkg::POS_W-1:0]       in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [csg_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  input  logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [csg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csg_pkg::POS_W-1:0]       cfg_wdata,
  output int                              mismatch_count,
  output int                              setpoints_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import csg_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] target;
    logic             written;
    logic [REM_W-1:0] remaining;
    logic             done;
  } setpoint_t;

  localparam longint unsigned DEPTH = TABLE_DEPTH;
  localparam longint unsigned ONE   = 64'd1073741824;

  longint              cos_table [0:TABLE_DEPTH];
  logic signed [47:0]  amp_reg;
  logic [PER_W-1:0]    period_reg;
  logic [PER_W-1:0]    count_reg;
  bit [TICK_W-1:0]     tick_count;
  logic [POS_W-1:0]    seg_base;
  setpoint_t           pending_setpoints [$];
  setpoint_t           want;

  // Quarter-wave entry from a truncated Taylor series in Q30.
  function automatic longint table_entry(longint unsigned r);
    longint unsigned x, x2, t;
    longint sum;
    x = (r * PI_Q30 + DEPTH) / (2 * DEPTH);
    x2 = (x * x) >> 30;
    t = ONE;
    sum = longint'(ONE);
    for (longint unsigned n = 1; n <= 7; n++) begin
      t = ((t * x2) >> 30) / ((2 * n - 1) * (2 * n));
      if (n[0]) sum -= longint'(t);
      else sum += longint'(t);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE)) sum = longint'(ONE);
    return sum;
  endfunction

  function automatic longint cosine_q30(longint unsigned k);
    longint unsigned q, r;
    q = (k / DEPTH) % 4;
    r = k % DEPTH;
    case (q)
      0: return cos_table[r];
      1: return -cos_table[DEPTH - r];
      2: return -cos_table[r];
      default: return cos_table[DEPTH - r];
    endcase
  endfunction

  // Signed (1-cos)/2 or (1-cos) term scaled by the amplitude, rounded half away from zero.
  function automatic longint swing_delta(longint unsigned phase, longint unsigned per, bit full);
    longint unsigned ph, k, w, mag;
    longint a, m;
    logic [95:0] prod;
    int sh;
    if (per == 0) return 0;
    ph = phase % per;
    k = (ph * 8 * DEPTH + per) / (2 * per);
    if (k >= 4 * DEPTH) k -= 4 * DEPTH;
    w = longint'(ONE) - cosine_q30(k);
    a = amp_reg;
    mag = (a < 0) ? -a : a;
    sh = full ? SHIFT_FULL : SHIFT_HALF;
    prod = 96'(mag) * 96'(w) + (96'd1 << (sh - 1));
    prod = prod >> sh;
    m = longint'(prod[63:0]);
    return (a < 0) ? -m : m;
  endfunction

  // Advances the tick counter and returns the setpoint that this tick produces.
  function automatic setpoint_t advance_tick(logic [POS_W-1:0] sample);
    setpoint_t res;
    longint per, half, total, c, delta, rem;
    bit wr;
    per = longint'(period_reg);
    half = per / 2;
    total = longint'(count_reg) * per;
    tick_count = tick_count + 32'd1;
    c = longint'(tick_count);
    wr = 1'b0;
    delta = 0;
    if (c >= 1 && c <= half) begin
      if (c == 1) seg_base = sample;
      delta = swing_delta(c, per, 1'b0);
      wr = 1'b1;
    end else if (c > half && c <= total - half) begin
      if (c == half + 1) seg_base = sample;
      delta = -swing_delta(c - half, per, 1'b1);
      wr = 1'b1;
    end else if (c > total - half && c <= total) begin
      if (c == total - half + 1) seg_base = sample;
      delta = -swing_delta(c - total + half, per, 1'b0);
      wr = 1'b1;
    end
    res.target = wr ? seg_base + delta[47:0] : '0;
    res.written = wr;
    rem = total - c;
    res.remaining = rem[REM_W-1:0];
    res.done = (rem <= 0);
    if (res.done) tick_count = '0;
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [87:0] got, logic [87:0] exp_val);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, exp_val);
    mismatch_count++;
  endtask

  initial begin
    mismatch_count = 0;
    setpoints_outstanding = 0;
    for (int r = 0; r <= TABLE_DEPTH; r++) cos_table[r] = table_entry(longint'(r));
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      amp_reg <= '0;
      period_reg <= PERIOD_TICKS_RST;
      count_reg <= PERIOD_COUNT_RST;
      tick_count = '0;
      seg_base = '0;
      pending_setpoints.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_setpoints.size() == 0) begin
          flag_mismatch("result with no tick pending", out_tdata, '0);
        end else begin
          want = pending_setpoints.pop_front();
          if (out_tdata[47:0] !== want.target)
            flag_mismatch("new_target", OUT_TDATA_W'(out_tdata[47:0]),
                          OUT_TDATA_W'(want.target));
          if (out_tdata[80:48] !== want.remaining)
            flag_mismatch("ticks_remaining", OUT_TDATA_W'(out_tdata[80:48]),
                          OUT_TDATA_W'(want.remaining));
          if (out_tdata[87:81] !== 7'd0)
            flag_mismatch("tdata padding", OUT_TDATA_W'(out_tdata[87:81]), '0);
          if (out_tuser !== want.written)
            flag_mismatch("target_written", OUT_TDATA_W'(out_tuser),
                          OUT_TDATA_W'(want.written));
          if (out_tlast !== want.done)
            flag_mismatch("move_done", OUT_TDATA_W'(out_tlast), OUT_TDATA_W'(want.done));
        end
      end
      if (in_tvalid && in_tready) pending_setpoints.push_back(advance_tick(in_tdata));
      if (cfg_we) begin
        case (cfg_index)
          CFG_AMPLITUDE:    amp_reg <= cfg_wdata;
          CFG_PERIOD_TICKS: period_reg <= cfg_wdata[PER_W-1:0];
          CFG_PERIOD_COUNT: count_reg <= cfg_wdata[PER_W-1:0];
          default: ;
        endcase
      end
    end
    setpoints_outstanding = pending_setpoints.size();
  end

endmodule

>>> dv/cosine_swing_trajectory_gen_test.sv
// Top of the testbench: clock, reset, tick stimulus, register writes and the verdict.
module cosine_swing_trajectory_gen_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csg_pkg::*;

  localparam int TABLE_DEPTH = 1024;

  // Index 3 is decoded by nobody; writes to it must leave the registers alone.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  localparam logic [POS_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [POS_W-1:0] POS_MIN = 48'h8000_0000_0000;

  // About 725 ticks, with sender gaps and receiver stalls, stay well under the
  // limit; it leaves a wide margin.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_TICKS = 700;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [POS_W-1:0]        in_tdata;    // [47:0] present_target
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;   // [47:0] new_target, [80:48] ticks_remaining,
                                        // [87:81] zero
  logic                    out_tuser;   // [0] target_written
  logic                    out_tlast;   // move_done
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [POS_W-1:0]        cfg_wdata;

  int mismatch_count;
  int setpoints_outstanding;
  int cycle_count;
  int idle_pct;
  int stall_pct;
  int ticks_sent;

  cosine_swing_trajectory_gen #(
    .COS_TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // The checker sits beside the block, watching all three channels on its own.
  cosine_swing_trajectory_gen_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .mismatch_count(mismatch_count),
    .setpoints_outstanding(setpoints_outstanding)
  );

  initial clk = 1'b0;
  always #1ns clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver decides its ready at every falling edge, so stalls can land on
  // any phase of the block's work, including while the next tick is computed.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Offers one tick and returns at the falling edge after its transaction. The
  // valid is only lowered when a gap follows, so a back-to-back tick never sees
  // valid dropped and raised in the same time step.
  task automatic send_tick(logic [POS_W-1:0] position);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= position;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Register writes happen only with the block idle: every result of the
  // ticks sent so far has been taken by the receiver.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [POS_W-1:0] value);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (setpoints_outstanding != 0);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] random_position();
    case ($urandom_range(9))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return '0;
      3: return '1;
      default: return POS_W'({$urandom, $urandom});
    endcase
  endfunction

  // Period and count registers ignore the upper write bits, so those bits
  // sometimes carry junk.
  function automatic logic [POS_W-1:0] period_word(logic [PER_W-1:0] value);
    logic [31:0] junk;
    junk = $urandom_range(1) ? $urandom : 32'd0;
    return {junk, value};
  endfunction

  // Picks a new setting. Short periods dominate so that whole moves finish
  // within a burst; the very long ones leave the move running into the next
  // setting, where the tick counter may already be past the new total.
  task automatic pick_setting();
    logic [PER_W-1:0] per;
    logic [PER_W-1:0] cnt;
    logic [POS_W-1:0] amp;
    case ($urandom_range(9))
      0: per = '0;
      1: per = '1;
      2: per = PER_W'($urandom_range(65535));
      default: per = PER_W'($urandom_range(1, 12));
    endcase
    case ($urandom_range(9))
      0: cnt = '0;
      1: cnt = '1;
      2: cnt = PER_W'($urandom_range(65535));
      default: cnt = PER_W'($urandom_range(1, 4));
    endcase
    case ($urandom_range(7))
      0: amp = POS_MAX;
      1: amp = POS_MIN;
      2: amp = '0;
      default: amp = POS_W'({$urandom, $urandom});
    endcase
    if ($urandom_range(3) != 0) write_reg(CFG_AMPLITUDE, amp);
    if ($urandom_range(3) != 0) write_reg(CFG_PERIOD_TICKS, period_word(per));
    if ($urandom_range(3) != 0) write_reg(CFG_PERIOD_COUNT, period_word(cnt));
    if ($urandom_range(7) == 0) write_reg(CFG_UNUSED_INDEX, POS_W'({$urandom, $urandom}));
  endtask

  initial begin
    int burst;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    ticks_sent = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults: zero amplitude, period 1000, two periods. The first
    // three ticks of the ramp out carry the position extremes.
    send_tick(POS_MAX);
    send_tick(POS_MIN);
    send_tick('0);

    // Change the setting in the middle of the move. With period 4 and three
    // periods the counter is already inside the swing, whose sampling tick
    // has passed, so the base from the first tick stays in force.
    write_reg(CFG_AMPLITUDE, POS_MAX);
    write_reg(CFG_PERIOD_TICKS, 48'd4);
    write_reg(CFG_PERIOD_COUNT, 48'd3);
    send_tick('1);
    send_tick(48'h5555_5555_5555);
    send_tick(48'hAAAA_AAAA_AAAA);
    send_tick(48'h0000_0001_0000);
    send_tick(48'hFFFF_FFFF_0000);
    send_tick(48'h1234_5678_9ABC);
    send_tick(48'h7FFF_0000_0000);
    send_tick(48'h8000_0000_0001);
    send_tick(48'h0000_FFFF_FFFF);

    // Most negative amplitude with a single period of three ticks: one tick
    // in each segment, each sampling its own base.
    write_reg(CFG_AMPLITUDE, POS_MIN);
    write_reg(CFG_PERIOD_TICKS, 48'd3);
    write_reg(CFG_PERIOD_COUNT, 48'd1);
    send_tick(POS_MAX);
    send_tick(POS_MIN);
    send_tick(48'h0000_0000_0001);

    // A write to the index past the register list must change nothing; then a
    // zero period puts the tick in no segment and ends the move at once.
    write_reg(CFG_UNUSED_INDEX, '1);
    write_reg(CFG_PERIOD_TICKS, 48'd0);
    send_tick(48'h3333_3333_3333);

    // Zero period count: the total is zero, but the first tick still ramps.
    write_reg(CFG_PERIOD_TICKS, 48'd4);
    write_reg(CFG_PERIOD_COUNT, 48'd0);
    send_tick(48'hCCCC_CCCC_CCCC);

    // Period of one: no half period, the single tick is a swing tick.
    write_reg(CFG_PERIOD_TICKS, 48'd1);
    write_reg(CFG_PERIOD_COUNT, 48'd1);
    send_tick(48'h0F0F_0F0F_0F0F);

    // Largest period and count with a random amplitude: a huge remaining count.
    write_reg(CFG_AMPLITUDE, POS_W'({$urandom, $urandom}));
    write_reg(CFG_PERIOD_TICKS, 48'hFFFF);
    write_reg(CFG_PERIOD_COUNT, 48'hFFFF);
    send_tick(random_position());
    send_tick(random_position());

    // Random bursts of ticks under four idling regimes: none, a sparse
    // sender, a stalling receiver, and both at once.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      while (ticks_sent < (phase + 1) * RANDOM_TICKS / 4) begin
        pick_setting();
        burst = $urandom_range(8, 48);
        for (int i = 0; i < burst; i++) begin
          send_tick(random_position());
          ticks_sent++;
        end
      end
    end
    in_tvalid <= 1'b0;

    // Drain every outstanding result, then give the block a margin to show
    // any stray transaction.
    do @(negedge clk); while (setpoints_outstanding != 0);
    repeat (200) @(negedge clk);

    if (mismatch_count == 0 && setpoints_outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/csg_pkg.sv
src/csg_div.sv
src/csg_cos_rom.sv
src/csg_datapath.sv
src/csg_ctrl.sv
src/cosine_swing_trajectory_gen.sv
src/csg_checker.sv
dv/cosine_swing_trajectory_gen_checker.sv
dv/cosine_swing_trajectory_gen_test.sv
